### hw/rtl/dpwp_pkg.sv
package dpwp_pkg;

  localparam int PIX_W      = 12;
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int WORLD_W    = 24;
  localparam int CENTER_W   = 16;
  localparam int INV_W      = 24;
  localparam int ROT_W      = 48;
  localparam int ROT_ENT_W  = 16;
  localparam int TRANS_W    = 63;
  localparam int TRANS_ENT_W = 21;
  localparam int DX_W       = 17;
  localparam int Z_W        = 14;
  localparam int CAM_W      = 28;

  localparam int COORD_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [DEPTH_W-1:0] DEPTH_MIN = 16'd10;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'd10000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  localparam logic [CFG_IDX_W-1:0] REG_INV_FX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_A  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_B  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_C  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS  = 3'd7;

  localparam logic [INV_W-1:0]    INV_F_RST = 24'd31957;
  localparam logic [CENTER_W-1:0] CX_RST    = 16'd5112;
  localparam logic [CENTER_W-1:0] CY_RST    = 16'd3832;
  localparam logic [ROT_W-1:0]    ROT_A_RST = 48'h0000_0000_4000;
  localparam logic [ROT_W-1:0]    ROT_B_RST = 48'h0000_4000_0000;
  localparam logic [ROT_W-1:0]    ROT_C_RST = 48'h4000_0000_0000;
  localparam logic [TRANS_W-1:0]  TRANS_RST = '0;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } color_t;

  typedef struct packed {
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic [Z_W-1:0]         depth;
    color_t                 color;
  } item_t;

  typedef struct packed {
    logic [INV_W-1:0]      inv_fx;
    logic [INV_W-1:0]      inv_fy;
    logic [2:0][ROT_W-1:0] rot;
    logic [TRANS_W-1:0]    trans;
  } cfg_t;

endpackage

### hw/rtl/dpwp_front.sv
module dpwp_front
  import dpwp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PIX_W-1:0]    pixel_row,
  input  logic [PIX_W-1:0]    pixel_col,
  input  logic [DEPTH_W-1:0]  depth_mm,
  input  color_t              color,
  input  logic [CENTER_W-1:0] center_x,
  input  logic [CENTER_W-1:0] center_y,
  output logic                push_valid,
  input  logic                push_ready,
  output item_t               push_item
);

  localparam int MASK_BITS = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
  localparam logic [PIX_W-1:0] COORD_MASK = PIX_W'((33'd1 << MASK_BITS) - 33'd1);

  logic [PIX_W-1:0] row_m;
  logic [PIX_W-1:0] col_m;
  logic             keep;
  logic             take;
  item_t            item_nxt;
  item_t            item_r;
  logic             vld_r;
  logic             vld_nxt;

  assign row_m = pixel_row & COORD_MASK;
  assign col_m = pixel_col & COORD_MASK;
  assign keep  = !row_m[0] && !col_m[0] && (depth_mm >= DEPTH_MIN) && (depth_mm <= DEPTH_MAX);

  assign in_ready = !vld_r || push_ready;
  assign take     = in_valid && in_ready && keep;

  always_comb begin
    item_nxt.dx    = $signed({1'b0, col_m, 4'b0000}) - $signed({1'b0, center_x});
    item_nxt.dy    = $signed({1'b0, row_m, 4'b0000}) - $signed({1'b0, center_y});
    item_nxt.depth = depth_mm[Z_W-1:0];
    item_nxt.color = color;
  end

  assign vld_nxt = (vld_r && !push_ready) || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign push_valid = vld_r;
  assign push_item  = item_r;

endmodule

### hw/rtl/dpwp_queue.sv
module dpwp_queue
  import dpwp_pkg::*;
#(
  parameter int WIDTH = $bits(item_t),
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r;
  logic [AW-1:0]    rd_r;
  logic [CW-1:0]    cnt_r;
  logic [AW-1:0]    wr_nxt;
  logic [AW-1:0]    rd_nxt;
  logic [CW-1:0]    cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != FULL);
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == LAST) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/dpwp_back.sv
module dpwp_back
  import dpwp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  item_t                     pop_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [WORLD_W-1:0] world_x,
  output logic signed [WORLD_W-1:0] world_y,
  output logic signed [WORLD_W-1:0] world_z,
  output color_t                    color
);

  localparam int NST   = 7;
  localparam int P1_W  = 32;
  localparam int P2_W  = 57;
  localparam int PR_W  = 44;
  localparam int ACC_W = 46;
  localparam int SH_W  = 32;
  localparam int SUM_W = 33;
  localparam logic signed [P2_W-1:0]  CAM_BIAS = P2_W'((64'd1 << 28) - 64'd1);
  localparam logic signed [ACC_W-1:0] ROT_BIAS = ACC_W'((64'd1 << 14) - 64'd1);
  localparam logic signed [SUM_W-1:0] W_MAX = SUM_W'(64'sd8388607);
  localparam logic signed [SUM_W-1:0] W_MIN = -SUM_W'(64'sd8388608);

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  color_t         col_r [NST];

  logic signed [P1_W-1:0]  px_r;
  logic signed [P1_W-1:0]  py_r;
  logic [Z_W-1:0]          z1_r;
  logic signed [P2_W-1:0]  ex_r;
  logic signed [P2_W-1:0]  ey_r;
  logic [Z_W-1:0]          z2_r;
  logic signed [CAM_W-1:0] cam_r [3];
  logic signed [PR_W-1:0]  prod_r [3][3];
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [SH_W-1:0]  sh_r [3];
  logic signed [WORLD_W-1:0] w_r [3];

  logic signed [P2_W-1:0]  exb;
  logic signed [P2_W-1:0]  eyb;
  logic signed [CAM_W-1:0] cam_nxt [3];
  logic signed [ACC_W-1:0] accb [3];
  logic signed [SH_W-1:0]  sh_nxt [3];
  logic signed [SUM_W-1:0] sum [3];
  logic signed [WORLD_W-1:0] w_nxt [3];

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign pop_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= pop_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      col_r[0] <= pop_item.color;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        col_r[k] <= col_r[k-1];
      end
    end
  end

  always_comb begin
    exb = ex_r + (ex_r[P2_W-1] ? CAM_BIAS : '0);
    eyb = ey_r + (ey_r[P2_W-1] ? CAM_BIAS : '0);
    cam_nxt[0] = CAM_W'(exb >>> 28);
    cam_nxt[1] = CAM_W'(eyb >>> 28);
    cam_nxt[2] = $signed({{(CAM_W - Z_W){1'b0}}, z2_r});
    for (int i = 0; i < 3; i++) begin
      accb[i]   = acc_r[i] + (acc_r[i][ACC_W-1] ? ROT_BIAS : '0);
      sh_nxt[i] = SH_W'(accb[i] >>> 14);
      sum[i]    = SUM_W'(sh_r[i])
                + SUM_W'($signed(cfg.trans[TRANS_ENT_W*i +: TRANS_ENT_W]));
      if (sum[i] > W_MAX) begin
        w_nxt[i] = WORLD_W'(W_MAX);
      end else if (sum[i] < W_MIN) begin
        w_nxt[i] = WORLD_W'(W_MIN);
      end else begin
        w_nxt[i] = WORLD_W'(sum[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px_r <= pop_item.dx * $signed({1'b0, pop_item.depth});
      py_r <= pop_item.dy * $signed({1'b0, pop_item.depth});
      z1_r <= pop_item.depth;
    end
    if (en[1]) begin
      ex_r <= px_r * $signed({1'b0, cfg.inv_fx});
      ey_r <= py_r * $signed({1'b0, cfg.inv_fy});
      z2_r <= z1_r;
    end
    if (en[2]) begin
      for (int j = 0; j < 3; j++) begin
        cam_r[j] <= cam_nxt[j];
      end
    end
    if (en[3]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= $signed(cfg.rot[i][ROT_ENT_W*j +: ROT_ENT_W]) * cam_r[j];
        end
      end
    end
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= ACC_W'(prod_r[i][0]) + ACC_W'(prod_r[i][1]) + ACC_W'(prod_r[i][2]);
      end
    end
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        sh_r[i] <= sh_nxt[i];
      end
    end
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        w_r[i] <= w_nxt[i];
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign world_x   = w_r[0];
  assign world_y   = w_r[1];
  assign world_z   = w_r[2];
  assign color     = col_r[NST-1];

endmodule

### hw/rtl/depth_pixel_to_world_point.sv
// An accepted pixel reaches its world point through the front register, a queue slot
// and seven back stages. Throughput: one word per cycle while out_ready is high;
// dropped pixels leave no result and no bubble.
// Each back stage holds only where it is full and its successor stalls.
// Reset: synchronous active-low rst_n clears all valid flags, the queue pointers
// and the configuration registers to their defaults; there is no clearing pass.
module depth_pixel_to_world_point
  import dpwp_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [PIX_W-1:0]          in_pixel_row,
  input  logic [PIX_W-1:0]          in_pixel_col,
  input  logic [DEPTH_W-1:0]        in_depth_mm,
  input  logic [COLOR_W-1:0]        in_blue,
  input  logic [COLOR_W-1:0]        in_green,
  input  logic [COLOR_W-1:0]        in_red,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [WORLD_W-1:0] out_world_x,
  output logic signed [WORLD_W-1:0] out_world_y,
  output logic signed [WORLD_W-1:0] out_world_z,
  output logic [COLOR_W-1:0]        out_blue,
  output logic [COLOR_W-1:0]        out_green,
  output logic [COLOR_W-1:0]        out_red
);

  localparam int ITEM_W = $bits(item_t);

  logic [INV_W-1:0]    inv_fx_r;
  logic [INV_W-1:0]    inv_fy_r;
  logic [CENTER_W-1:0] cx_r;
  logic [CENTER_W-1:0] cy_r;
  logic [ROT_W-1:0]    rot_a_r;
  logic [ROT_W-1:0]    rot_b_r;
  logic [ROT_W-1:0]    rot_c_r;
  logic [TRANS_W-1:0]  trans_r;
  cfg_t                cfg;

  color_t              in_color;
  color_t              res_color;
  logic                fr_valid;
  logic                fr_ready;
  item_t               fr_item;
  logic                q_valid;
  logic                q_ready;
  logic [ITEM_W-1:0]   q_data;
  item_t               q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_fx_r <= INV_F_RST;
      inv_fy_r <= INV_F_RST;
      cx_r     <= CX_RST;
      cy_r     <= CY_RST;
      rot_a_r  <= ROT_A_RST;
      rot_b_r  <= ROT_B_RST;
      rot_c_r  <= ROT_C_RST;
      trans_r  <= TRANS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_FX: inv_fx_r <= cfg_data[INV_W-1:0];
        REG_INV_FY: inv_fy_r <= cfg_data[INV_W-1:0];
        REG_CX:     cx_r     <= cfg_data[CENTER_W-1:0];
        REG_CY:     cy_r     <= cfg_data[CENTER_W-1:0];
        REG_ROT_A:  rot_a_r  <= cfg_data[ROT_W-1:0];
        REG_ROT_B:  rot_b_r  <= cfg_data[ROT_W-1:0];
        REG_ROT_C:  rot_c_r  <= cfg_data[ROT_W-1:0];
        REG_TRANS:  trans_r  <= cfg_data[TRANS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.inv_fx = inv_fx_r;
    cfg.inv_fy = inv_fy_r;
    cfg.rot[0] = rot_a_r;
    cfg.rot[1] = rot_b_r;
    cfg.rot[2] = rot_c_r;
    cfg.trans  = trans_r;
  end

  always_comb begin
    in_color.blue  = in_blue;
    in_color.green = in_green;
    in_color.red   = in_red;
  end

  dpwp_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_row  (in_pixel_row),
    .pixel_col  (in_pixel_col),
    .depth_mm   (in_depth_mm),
    .color      (in_color),
    .center_x   (cx_r),
    .center_y   (cy_r),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item)
  );

  dpwp_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_item = item_t'(q_data);

  dpwp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .world_x   (out_world_x),
    .world_y   (out_world_y),
    .world_z   (out_world_z),
    .color     (res_color)
  );

  assign out_blue  = res_color.blue;
  assign out_green = res_color.green;
  assign out_red   = res_color.red;

  a_drop_odd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_pixel_row[0] || in_pixel_col[0]) |=> !fr_valid)
    else $error("odd pixel reached the queue");

  a_keep_good: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_pixel_row[0] && !in_pixel_col[0] &&
    (in_depth_mm >= DEPTH_MIN) && (in_depth_mm <= DEPTH_MAX) |=> fr_valid)
    else $error("kept pixel lost in front stage");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid || fr_ready)
    else $error("queue full and empty at once");

endmodule
